// ----- design/task_table_ready_queue_defines.svh -----
// ----------------------------------------------------------------------------
// task table ready queue assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TASK_TABLE_READY_QUEUE_DEFINES_SVH
`define TASK_TABLE_READY_QUEUE_DEFINES_SVH

// same-cycle implication
`define TTRQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttrq check failed");

// next-cycle implication
`define TTRQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttrq check failed");

`endif

// ----- design/ttrq_pkg.sv -----
// ----------------------------------------------------------------------------
// ttrq_pkg
// codes and control types shared by the task table ready queue
// ----------------------------------------------------------------------------
`default_nettype none

package ttrq_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 3'd1;
    localparam logic [OP_W-1:0] OP_POP     = 3'd2;
    localparam logic [OP_W-1:0] OP_BLOCK   = 3'd3;
    localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd4;
    localparam logic [OP_W-1:0] OP_REQUEUE = 3'd5;

    localparam logic [STATUS_W-1:0] RES_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] RES_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] RES_IGNORED = 2'd2;
    localparam logic [STATUS_W-1:0] RES_EMPTY   = 2'd3;

    localparam logic [1:0] ST_READY      = 2'd0;
    localparam logic [1:0] ST_DISPATCHED = 2'd1;
    localparam logic [1:0] ST_BLOCKED    = 2'd2;

    typedef struct packed {
        logic load;
        logic read;
        logic exec;
        logic link;
    } t_dp_cmd;

    typedef struct packed {
        logic need_link;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/task_table_ready_queue.sv -----
// ----------------------------------------------------------------------------
// task_table_ready_queue
// task slot table with a first-in-first-out ready queue
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. It passes through
// the read and execute states to the result state, with a link state between
// when a task is appended behind an existing tail, since the next-link memory
// has one write port and the old tail's link is written in a state of its own.
// The result appears for one cycle with o_done high; it cannot be stalled, so
// the receiver must capture it then. busy is low again in the cycle after
// o_done, so no new command is accepted before the last result has appeared.
// Reset is synchronous; the link memories need no clearing pass.
`default_nettype none

module task_table_ready_queue #(
    parameter int TASK_SLOTS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_operation,
    input  wire logic [5:0]  i_slot,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [5:0]       o_result_slot,
    output logic [31:0]      o_task_id
);

    ttrq_pkg::t_dp_cmd  cmd;
    ttrq_pkg::t_dp_stat stat;

    ttrq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    ttrq_dpath #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operation   (i_operation),
        .i_slot        (i_slot),
        .o_stat        (stat),
        .o_status      (o_status),
        .o_result_slot (o_result_slot),
        .o_task_id     (o_task_id)
    );

endmodule

`default_nettype wire

// ----- design/ttrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttrq_ctrl
// command sequencer: read, execute, optional tail link, result
// ----------------------------------------------------------------------------
`default_nettype none

module ttrq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire ttrq_pkg::t_dp_stat i_stat,
    output ttrq_pkg::t_dp_cmd       o_cmd,
    output logic                    busy,
    output logic                    o_done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_LINK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC:  n_state = i_stat.need_link ? S_LINK : S_DONE;
            S_LINK:  n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_done     = (r_state == S_DONE);
    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.read = (r_state == S_READ);
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.link = (r_state == S_LINK);

endmodule

`default_nettype wire

// ----- design/ttrq_dpath.sv -----
// ----------------------------------------------------------------------------
// ttrq_dpath
// task slot tables, queue link memories and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module ttrq_dpath #(
    parameter int TASK_SLOTS = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ttrq_pkg::t_dp_cmd i_cmd,
    input  wire logic [2:0]        i_operation,
    input  wire logic [5:0]        i_slot,
    output ttrq_pkg::t_dp_stat     o_stat,
    output logic [1:0]             o_status,
    output logic [5:0]             o_result_slot,
    output logic [31:0]            o_task_id
);

    localparam int SW = $clog2(TASK_SLOTS);

    // command latch
    logic [2:0]            r_op;
    logic [5:0]            r_raw;
    logic [SW-1:0]         r_s;
    logic                  r_inrange;

    // control state
    logic [TASK_SLOTS-1:0] r_used;
    logic [TASK_SLOTS-1:0] r_queued;
    logic [SW-1:0]         r_head;
    logic [SW-1:0]         r_tail;
    logic                  r_empty;
    logic [31:0]           r_next_id;

    // memories
    logic [1:0]            r_status_mem [TASK_SLOTS];
    logic [31:0]           r_id_mem     [TASK_SLOTS];
    logic [SW-1:0]         r_next_mem   [TASK_SLOTS];
    logic [SW-1:0]         r_prev_mem   [TASK_SLOTS];

    // read stage
    logic [SW-1:0]         r_tgt;
    logic [1:0]            r_rd_status;
    logic [31:0]           r_rd_id;
    logic [SW-1:0]         r_rd_next;
    logic [SW-1:0]         r_rd_prev;
    logic [SW-1:0]         r_free;
    logic                  r_full;

    // tail link stage
    logic [SW-1:0]         r_link_addr;
    logic [SW-1:0]         r_link_x;

    // results
    logic [1:0]            r_res_status;
    logic [5:0]            r_res_slot;
    logic [31:0]           r_res_id;

    logic [SW-1:0]         n_free;
    logic                  n_full;
    logic [SW-1:0]         rd_addr;

    logic                  e_valid;
    logic                  e_unlink;
    logic                  e_append;
    logic                  e_st_we;
    logic                  e_id_we;
    logic                  e_use_set;
    logic                  e_use_clr;
    logic [1:0]            e_st_val;
    logic [1:0]            e_need;
    logic [SW-1:0]         e_wa;
    logic [1:0]            e_res_status;
    logic [5:0]            e_res_slot;
    logic [31:0]           e_res_id;
    logic                  at_head;
    logic                  at_tail;

    // lowest free slot from 1 upward
    always_comb begin
        n_free = '0;
        n_full = 1'b1;
        for (int i = TASK_SLOTS - 1; i >= 1; i--) begin
            if (!r_used[i]) begin
                n_free = SW'(i);
                n_full = 1'b0;
            end
        end
    end

    assign rd_addr = (r_op == ttrq_pkg::OP_POP) ? r_head : r_s;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_raw     <= i_slot;
            r_s       <= SW'(i_slot);
            r_inrange <= (int'(i_slot) < TASK_SLOTS);
        end
        if (i_cmd.read) begin
            r_tgt  <= rd_addr;
            r_free <= n_free;
            r_full <= n_full;
        end
    end

    assign at_head = (r_tgt == r_head);
    assign at_tail = (r_tgt == r_tail);
    assign e_valid = r_inrange && (r_s != '0) && r_used[r_s];
    assign e_wa    = (r_op == ttrq_pkg::OP_CREATE) ? r_free : r_tgt;
    assign e_need  = (r_op == ttrq_pkg::OP_UNBLOCK) ? ttrq_pkg::ST_BLOCKED
                                                    : ttrq_pkg::ST_DISPATCHED;

    always_comb begin
        e_unlink     = 1'b0;
        e_append     = 1'b0;
        e_st_we      = 1'b0;
        e_id_we      = 1'b0;
        e_use_set    = 1'b0;
        e_use_clr    = 1'b0;
        e_st_val     = ttrq_pkg::ST_READY;
        e_res_status = ttrq_pkg::RES_IGNORED;
        e_res_slot   = r_raw;
        e_res_id     = '0;
        unique case (r_op)
            ttrq_pkg::OP_CREATE: begin
                e_res_slot = '0;
                if (r_full) begin
                    e_res_status = ttrq_pkg::RES_FULL;
                end else begin
                    e_append     = 1'b1;
                    e_st_we      = 1'b1;
                    e_id_we      = 1'b1;
                    e_use_set    = 1'b1;
                    e_res_status = ttrq_pkg::RES_DONE;
                    e_res_slot   = 6'(r_free);
                    e_res_id     = r_next_id;
                end
            end
            ttrq_pkg::OP_POP: begin
                e_res_slot = '0;
                if (r_empty) begin
                    e_res_status = ttrq_pkg::RES_EMPTY;
                end else begin
                    e_unlink     = 1'b1;
                    e_st_we      = 1'b1;
                    e_st_val     = ttrq_pkg::ST_DISPATCHED;
                    e_res_status = ttrq_pkg::RES_DONE;
                    e_res_slot   = 6'(r_tgt);
                    e_res_id     = r_rd_id;
                end
            end
            ttrq_pkg::OP_DESTROY: begin
                if (e_valid) begin
                    e_unlink     = r_queued[r_tgt];
                    e_use_clr    = 1'b1;
                    e_res_status = ttrq_pkg::RES_DONE;
                    e_res_slot   = 6'(r_tgt);
                    e_res_id     = r_rd_id;
                end
            end
            ttrq_pkg::OP_BLOCK: begin
                if (e_valid && (r_rd_status != ttrq_pkg::ST_BLOCKED)) begin
                    e_unlink     = r_queued[r_tgt];
                    e_st_we      = 1'b1;
                    e_st_val     = ttrq_pkg::ST_BLOCKED;
                    e_res_status = ttrq_pkg::RES_DONE;
                    e_res_slot   = 6'(r_tgt);
                    e_res_id     = r_rd_id;
                end
            end
            ttrq_pkg::OP_UNBLOCK, ttrq_pkg::OP_REQUEUE: begin
                if (e_valid && (r_rd_status == e_need)) begin
                    e_append     = !r_queued[r_tgt];
                    e_st_we      = 1'b1;
                    e_res_status = ttrq_pkg::RES_DONE;
                    e_res_slot   = 6'(r_tgt);
                    e_res_id     = r_rd_id;
                end
            end
            default: begin
                e_res_slot = '0;
            end
        endcase
    end

    assign o_stat.need_link = e_append && !r_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= TASK_SLOTS'(1);
            r_queued  <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_empty   <= 1'b1;
            r_next_id <= 32'd1;
        end else if (i_cmd.exec) begin
            if (e_use_set) r_used[e_wa] <= 1'b1;
            if (e_use_clr) r_used[r_tgt] <= 1'b0;
            if (e_id_we) r_next_id <= r_next_id + 32'd1;
            if (e_unlink) begin
                r_queued[r_tgt] <= 1'b0;
                if (at_head && at_tail) begin
                    r_empty <= 1'b1;
                    r_head  <= '0;
                    r_tail  <= '0;
                end else if (at_head) begin
                    r_head <= r_rd_next;
                end else if (at_tail) begin
                    r_tail <= r_rd_prev;
                end
            end
            if (e_append) begin
                r_queued[e_wa] <= 1'b1;
                if (r_empty) r_head <= e_wa;
                r_tail  <= e_wa;
                r_empty <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_link_addr  <= r_tail;
            r_link_x     <= e_wa;
            r_res_status <= e_res_status;
            r_res_slot   <= e_res_slot;
            r_res_id     <= e_res_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && e_st_we) r_status_mem[e_wa] <= e_st_val;
        if (i_cmd.read) r_rd_status <= r_status_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && e_id_we) r_id_mem[e_wa] <= r_next_id;
        if (i_cmd.read) r_rd_id <= r_id_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.link) begin
            r_next_mem[r_link_addr] <= r_link_x;
        end else if (i_cmd.exec && e_append) begin
            r_next_mem[e_wa] <= e_wa;
        end else if (i_cmd.exec && e_unlink && !at_head) begin
            r_next_mem[r_rd_prev] <= at_tail ? r_rd_prev : r_rd_next;
        end
        if (i_cmd.read) r_rd_next <= r_next_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && e_append) begin
            r_prev_mem[e_wa] <= r_empty ? e_wa : r_tail;
        end else if (i_cmd.exec && e_unlink && !at_tail) begin
            r_prev_mem[r_rd_next] <= at_head ? r_rd_next : r_rd_prev;
        end
        if (i_cmd.read) r_rd_prev <= r_prev_mem[rd_addr];
    end

    assign o_status      = r_res_status;
    assign o_result_slot = r_res_slot;
    assign o_task_id     = r_res_id;

endmodule

`default_nettype wire

// ----- design/ttrq_checker.sv -----
// ----------------------------------------------------------------------------
// ttrq_checker
// port-level checks on command transfer and result strobe
// ----------------------------------------------------------------------------
`default_nettype none

`include "task_table_ready_queue_defines.svh"

module ttrq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [5:0]  result_slot,
    input wire logic [31:0] task_id
);

    logic res_none;

    assign res_none = done && (status == ttrq_pkg::RES_FULL ||
                               status == ttrq_pkg::RES_EMPTY);

    `TTRQ_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `TTRQ_ASSERT_IMP(a_done_busy, done, busy)
    `TTRQ_ASSERT_NXT(a_done_pulse, done, !done && !busy)
    `TTRQ_ASSERT_IMP(a_fail_zero, res_none, result_slot == 6'd0 && task_id == 32'd0)

endmodule

bind task_table_ready_queue ttrq_checker u_ttrq_checker (
    .clk         (i_clk),
    .rst_n       (i_rst_n),
    .start       (start),
    .busy        (busy),
    .done        (o_done),
    .status      (o_status),
    .result_slot (o_result_slot),
    .task_id     (o_task_id)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// checks task table commands and ready queue order against a local predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

    localparam int NSLOT = 64;
    localparam int LIMIT = 200000;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] slot;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [31:0] id;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic [2:0] i_operation = '0;
    logic [5:0] i_slot = '0;
    logic busy, o_done;
    logic [1:0] o_status;
    logic [5:0] o_result_slot;
    logic [31:0] o_task_id;

    task_table_ready_queue i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_slot(i_slot), .o_done(o_done),
        .o_status(o_status), .o_result_slot(o_result_slot), .o_task_id(o_task_id)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    bit          used [NSLOT];
    logic [1:0]  tstat [NSLOT];
    logic [31:0] tid [NSLOT];
    bit          queued [NSLOT];
    int          nxt [NSLOT];
    int          prv [NSLOT];
    int          head, tail;
    bit          qempty;
    logic [31:0] id_count;

    t_cmd pending_cmds[$];
    t_res expected_results[$];
    int   phase = 0;
    bit   failed = 0;
    int   cycles = 0;

    function void table_reset();
        for (int i = 0; i < NSLOT; i++) begin
            used[i] = 0; tstat[i] = ttrq_pkg::ST_READY; tid[i] = 0; queued[i] = 0;
            nxt[i] = 0; prv[i] = 0;
        end
        used[0] = 1; head = 0; tail = 0; qempty = 1; id_count = 1;
    endfunction

    function void q_append(int s);
        if (qempty) begin
            head = s; prv[s] = s;
        end else begin
            nxt[tail] = s; prv[s] = tail;
        end
        nxt[s] = s; tail = s; qempty = 0; queued[s] = 1;
    endfunction

    function void q_unlink(int s);
        int p, n;
        p = prv[s]; n = nxt[s];
        if (s == head && s == tail) begin
            qempty = 1; head = 0; tail = 0;
        end else if (s == head) begin
            head = n; prv[n] = n;
        end else if (s == tail) begin
            tail = p; nxt[p] = p;
        end else begin
            nxt[p] = n; prv[n] = p;
        end
        queued[s] = 0;
    endfunction

    function t_res predict_command(t_cmd c);
        t_res r;
        int s;
        bit ok;
        logic [1:0] need;
        s = c.slot;
        ok = (s != 0) && used[s];
        r = '{ttrq_pkg::RES_IGNORED, c.slot, 32'd0};
        case (c.op)
            ttrq_pkg::OP_CREATE: begin
                r = '{ttrq_pkg::RES_FULL, 6'd0, 32'd0};
                for (int i = 1; i < NSLOT; i++) begin
                    if (!used[i]) begin
                        used[i] = 1; tstat[i] = ttrq_pkg::ST_READY; tid[i] = id_count;
                        q_append(i);
                        r = '{ttrq_pkg::RES_DONE, 6'(i), id_count};
                        id_count = id_count + 1;
                        break;
                    end
                end
            end
            ttrq_pkg::OP_POP: begin
                if (qempty) begin
                    r = '{ttrq_pkg::RES_EMPTY, 6'd0, 32'd0};
                end else begin
                    s = head; q_unlink(s); tstat[s] = ttrq_pkg::ST_DISPATCHED;
                    r = '{ttrq_pkg::RES_DONE, 6'(s), tid[s]};
                end
            end
            ttrq_pkg::OP_DESTROY: if (ok) begin
                r = '{ttrq_pkg::RES_DONE, c.slot, tid[s]};
                if (queued[s]) q_unlink(s);
                used[s] = 0; tstat[s] = ttrq_pkg::ST_READY; tid[s] = 0;
            end
            ttrq_pkg::OP_BLOCK: if (ok && tstat[s] != ttrq_pkg::ST_BLOCKED) begin
                if (queued[s]) q_unlink(s);
                tstat[s] = ttrq_pkg::ST_BLOCKED;
                r = '{ttrq_pkg::RES_DONE, c.slot, tid[s]};
            end
            ttrq_pkg::OP_UNBLOCK, ttrq_pkg::OP_REQUEUE: begin
                need = (c.op == ttrq_pkg::OP_UNBLOCK) ? ttrq_pkg::ST_BLOCKED
                                                      : ttrq_pkg::ST_DISPATCHED;
                if (ok && tstat[s] == need) begin
                    tstat[s] = ttrq_pkg::ST_READY;
                    if (!queued[s]) q_append(s);
                    r = '{ttrq_pkg::RES_DONE, c.slot, tid[s]};
                end
            end
            default: r = '{ttrq_pkg::RES_IGNORED, 6'd0, 32'd0};
        endcase
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && busy) begin
                // hold the command until accepted
            end else if (pending_cmds.size() != 0 &&
                         !(phase == 0 && $urandom_range(99) < 37) &&
                         !(phase == 1 && $urandom_range(99) < 61)) begin
                t_cmd c;
                c = pending_cmds.pop_front();
                start <= 1'b1;
                i_operation <= c.op;
                i_slot <= c.slot;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // predict on each accepted transfer
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            expected_results.push_back(predict_command('{i_operation, i_slot}));
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result st=%0d slot=%0d id=%0d", $time,
                         o_status, o_result_slot, o_task_id);
                failed = 1;
            end else begin
                t_res e;
                e = expected_results.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, o_status);
                    failed = 1;
                end
                if (o_result_slot !== e.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, e.slot,
                             o_result_slot);
                    failed = 1;
                end
                if (o_task_id !== e.id) begin
                    $display("%0t: task id expected %0d actual %0d", $time, e.id, o_task_id);
                    failed = 1;
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("task_table_ready_queue test failed");
            $finish;
        end
    end

    // stimulus shadow to target live slots
    bit live [NSLOT];

    function t_cmd rand_cmd();
        t_cmd c;
        int r;
        r = $urandom_range(99);
        c.slot = 6'($urandom_range(63));
        if (r < 3) c.op = 3'($urandom_range(7));
        else if (r < 30) c.op = ttrq_pkg::OP_CREATE;
        else if (r < 50) c.op = ttrq_pkg::OP_POP;
        else if (r < 62) c.op = ttrq_pkg::OP_DESTROY;
        else if (r < 74) c.op = ttrq_pkg::OP_BLOCK;
        else if (r < 86) c.op = ttrq_pkg::OP_UNBLOCK;
        else c.op = ttrq_pkg::OP_REQUEUE;
        if (r >= 3 && $urandom_range(9) < 8) begin
            for (int k = 0; k < 8; k++) begin
                if (live[c.slot]) break;
                c.slot = 6'($urandom_range(1, 20));
            end
        end
        return c;
    endfunction

    initial begin
        t_cmd c;
        table_reset();
        for (int i = 0; i < NSLOT; i++) live[i] = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty pop, idle slot, bad ops, fill, full, every state move
        pending_cmds.push_back('{ttrq_pkg::OP_POP, 6'd0});
        pending_cmds.push_back('{ttrq_pkg::OP_DESTROY, 6'd0});
        pending_cmds.push_back('{ttrq_pkg::OP_BLOCK, 6'd63});
        pending_cmds.push_back('{3'd6, 6'd5});
        pending_cmds.push_back('{3'd7, 6'd63});
        for (int i = 0; i < 64; i++) pending_cmds.push_back('{ttrq_pkg::OP_CREATE, 6'd63});
        pending_cmds.push_back('{ttrq_pkg::OP_BLOCK, 6'd3});
        pending_cmds.push_back('{ttrq_pkg::OP_BLOCK, 6'd3});
        pending_cmds.push_back('{ttrq_pkg::OP_DESTROY, 6'd10});
        pending_cmds.push_back('{ttrq_pkg::OP_POP, 6'd0});
        pending_cmds.push_back('{ttrq_pkg::OP_REQUEUE, 6'd1});
        pending_cmds.push_back('{ttrq_pkg::OP_UNBLOCK, 6'd3});
        pending_cmds.push_back('{ttrq_pkg::OP_POP, 6'd0});
        pending_cmds.push_back('{ttrq_pkg::OP_BLOCK, 6'd2});
        pending_cmds.push_back('{ttrq_pkg::OP_UNBLOCK, 6'd2});
        pending_cmds.push_back('{ttrq_pkg::OP_DESTROY, 6'd63});
        pending_cmds.push_back('{ttrq_pkg::OP_DESTROY, 6'd3});
        pending_cmds.push_back('{ttrq_pkg::OP_REQUEUE, 6'd4});
        pending_cmds.push_back('{ttrq_pkg::OP_CREATE, 6'd0});
        for (int i = 1; i < 64; i++) live[i] = 1;

        for (int p = 0; p < 3; p++) begin
            wait (pending_cmds.size() == 0 && expected_results.size() == 0);
            phase = p;
            for (int n = 0; n < 300; n++) begin
                c = rand_cmd();
                if (c.op == ttrq_pkg::OP_DESTROY) live[c.slot] = 0;
                if (c.op == ttrq_pkg::OP_CREATE)
                    for (int k = 1; k < NSLOT; k++)
                        if (!live[k]) begin
                            live[k] = 1;
                            break;
                        end
                pending_cmds.push_back(c);
            end
            // drain the table after the second random phase so creates walk all slots again
            if (p == 1)
                for (int k = 1; k < NSLOT; k++) begin
                    pending_cmds.push_back('{ttrq_pkg::OP_DESTROY, 6'(k)});
                    live[k] = 0;
                end
        end
        wait (pending_cmds.size() == 0 && expected_results.size() == 0);
        @(posedge i_clk);
        wait (!start);
        repeat (20) @(posedge i_clk);
        if (!failed)
            $display("task_table_ready_queue test passed");
        else
            $display("task_table_ready_queue test failed");
        $finish;
    end
endmodule

`default_nettype wire

// ----- files.f -----
+incdir+design
design/ttrq_pkg.sv
design/ttrq_ctrl.sv
design/ttrq_dpath.sv
design/task_table_ready_queue.sv
design/ttrq_checker.sv
tb/tb_top.sv
